// File: design/separable_gaussian_blur_unit_defines.svh
// Assertion macros shared by the blur unit's checker.
`ifndef SEPARABLE_GAUSSIAN_BLUR_UNIT_DEFINES_SVH
`define SEPARABLE_GAUSSIAN_BLUR_UNIT_DEFINES_SVH

// Condition in this cycle implies a condition in the next cycle.
`define SGB_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sgb checker: next-cycle property failed");

// Condition implies another condition in the same cycle.
`define SGB_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sgb checker: same-cycle property failed");

`endif

// File: design/sgb_pkg.sv
// Shared constants, types and the weight selector of the blur unit.
package sgb_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_RADIUS = 7;
  localparam int TAPS       = 2 * MAX_RADIUS + 1;
  localparam int SLOTS      = 3 * MAX_RADIUS + 1;

  localparam int XW      = $clog2(MAX_WIDTH);
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int TAP_W   = $clog2(TAPS);
  localparam int DIM_W   = 11;
  localparam int RAD_W   = 3;
  localparam int WGT_W   = 64;
  localparam int PIX_W   = 8;
  localparam int COEF_W  = 16;
  localparam int HSUM_W  = 16;
  localparam int HPROD_W = PIX_W + COEF_W;
  localparam int VPROD_W = HSUM_W + COEF_W;
  localparam int CNT_W   = 21;
  localparam int OCNT_W  = 20;
  localparam int LAG_W   = 13;
  localparam int CIDX_W  = 3;

  // Register indexes of the configuration port.
  typedef enum logic [CIDX_W-1:0] {
    REG_WIDTH   = 3'd0,
    REG_HEIGHT  = 3'd1,
    REG_RADIUS  = 3'd2,
    REG_WLOW    = 3'd3,
    REG_WHIGH   = 3'd4
  } reg_idx_t;

  // Controls for the horizontal cell row.
  typedef struct packed {
    logic shift;
    logic clr;
    logic wipe;
    logic mul;
  } hctl_t;

  // Controls for the vertical cell row.
  typedef struct packed {
    logic we;
    logic rd;
    logic mul;
  } vctl_t;

  // Q1.15 weight of distance d from the two packed weight registers.
  function automatic logic [COEF_W-1:0] tap_weight(input logic [WGT_W-1:0] wl,
                                                   input logic [WGT_W-1:0] wh,
                                                   input logic [2:0] d);
    logic [WGT_W-1:0] src;
    src = d[2] ? wh : wl;
    return src[{d[1:0], 4'b0000} +: COEF_W];
  endfunction

endpackage

// File: design/sgb_hcell.sv
// One horizontal cell: a row window tap with its own weight multiplier.
module sgb_hcell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  sgb_pkg::hctl_t              ctl,
  input  logic [sgb_pkg::TAP_W-1:0]   cell_k,
  input  logic [2:0]                  tgt_j,
  input  logic [sgb_pkg::RAD_W-1:0]   radius,
  input  logic [sgb_pkg::WGT_W-1:0]   wlow,
  input  logic [sgb_pkg::WGT_W-1:0]   whigh,
  input  logic [sgb_pkg::PIX_W-1:0]   pix_i,
  output logic [sgb_pkg::PIX_W-1:0]   pix_o,
  output logic [sgb_pkg::HPROD_W-1:0] prod_o
);

  logic [sgb_pkg::PIX_W-1:0]   pix_r;
  logic [sgb_pkg::HPROD_W-1:0] prod_r;
  logic signed [5:0]           diff;
  logic                        tap_on;
  logic [2:0]                  mag;
  logic [sgb_pkg::COEF_W-1:0]  wt;

  // The cell's distance from the target column selects its weight.
  always_comb begin
    diff   = $signed({2'b00, cell_k}) - $signed({3'b000, tgt_j});
    tap_on = (diff <= $signed({3'b000, radius}));
    mag    = diff[5] ? 3'(-diff) : diff[2:0];
    wt     = tap_on ? sgb_pkg::tap_weight(wlow, whigh, mag) : '0;
  end

  // Window tap: shifts toward the older end; a new row starts from zeros.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (ctl.wipe) begin
      pix_r <= '0;
    end else if (ctl.shift) begin
      pix_r <= (ctl.clr && (cell_k != '0)) ? '0 : pix_i;
    end
  end

  // Registered tap product.
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= {{sgb_pkg::COEF_W{1'b0}}, pix_r} * {{sgb_pkg::PIX_W{1'b0}}, wt};
    end
  end

  assign pix_o  = pix_r;
  assign prod_o = prod_r;

endmodule

// File: design/sgb_vcell.sv
// One vertical cell: a line bank of horizontal sums with its own weight multiplier.
module sgb_vcell (
  input  logic                         clk,
  input  sgb_pkg::vctl_t               ctl,
  input  logic [sgb_pkg::SLOT_W-1:0]   cell_id,
  input  logic [sgb_pkg::SLOT_W-1:0]   wslot,
  input  logic [sgb_pkg::XW-1:0]       waddr,
  input  logic [sgb_pkg::HSUM_W-1:0]   wdata,
  input  logic [sgb_pkg::XW-1:0]       raddr,
  input  logic [sgb_pkg::SLOT_W-1:0]   out_slot,
  input  logic [sgb_pkg::RAD_W-1:0]    radius,
  input  logic [sgb_pkg::XW-1:0]       out_y,
  input  logic [sgb_pkg::DIM_W-1:0]    height,
  input  logic [sgb_pkg::WGT_W-1:0]    wlow,
  input  logic [sgb_pkg::WGT_W-1:0]    whigh,
  output logic [sgb_pkg::VPROD_W-1:0]  prod_o
);

  logic [sgb_pkg::HSUM_W-1:0]  mem [0:sgb_pkg::MAX_WIDTH-1];
  logic [sgb_pkg::HSUM_W-1:0]  rdata_r;
  logic [sgb_pkg::VPROD_W-1:0] prod_r;
  logic [5:0]                  d6;
  logic [5:0]                  mag6;
  logic                        fwd;
  logic                        back;
  logic signed [11:0]          tofs;
  logic signed [11:0]          q;
  logic                        inframe;
  logic [sgb_pkg::COEF_W-1:0]  wt;

  // Row offset of this bank relative to the output row, and its weight.
  always_comb begin
    if (cell_id >= out_slot) begin
      d6 = {1'b0, cell_id} - {1'b0, out_slot};
    end else begin
      d6 = {1'b0, cell_id} + 6'(sgb_pkg::SLOTS) - {1'b0, out_slot};
    end
    fwd     = (d6 <= {3'b000, radius});
    back    = (d6 >= (6'(sgb_pkg::SLOTS) - {3'b000, radius}));
    mag6    = fwd ? d6 : (6'(sgb_pkg::SLOTS) - d6);
    tofs    = fwd ? $signed({6'b0, d6}) : -$signed({6'b0, mag6});
    q       = $signed({2'b00, out_y}) + tofs;
    inframe = !q[11] && (q < $signed({1'b0, height}));
    wt      = ((fwd || back) && inframe) ? sgb_pkg::tap_weight(wlow, whigh, mag6[2:0]) : '0;
  end

  // Line bank: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.we && (wslot == cell_id)) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rdata_r <= mem[raddr];
    end
  end

  // Registered tap product.
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod_r <= {{sgb_pkg::COEF_W{1'b0}}, rdata_r} * {{sgb_pkg::HSUM_W{1'b0}}, wt};
    end
  end

  assign prod_o = prod_r;

endmodule

// File: design/separable_gaussian_blur_unit.sv
// Separable blur unit: a row of 15 window cells for the horizontal pass and a
// row of 22 line-bank cells for the vertical pass. The unit works on one beat at
// a time. A pixel beat takes one pass through the shared multiply, partial-sum
// and final-sum steps for each horizontal sum it completes (none on the first
// radius pixels of a row but the last, one in the middle of a row, up to
// radius+1 on the last pixel of a row), and one more pass when it yields an
// output; a drain beat takes a pass only when it yields an output.
// Outputs trail the input by radius*width+radius pixels.
// The line banks need no clearing pass: every entry the vertical pass reads with
// a nonzero weight has been written in the same frame. A write to width, height or radius restarts
// the stream; weight writes take effect at once.
module separable_gaussian_blur_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [sgb_pkg::PIX_W-1:0]   in_pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sgb_pkg::PIX_W-1:0]   out_pixel,
  output logic                        out_end_of_frame,
  input  logic                        cfg_we,
  input  logic [sgb_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [sgb_pkg::WGT_W-1:0]   cfg_wdata
);

  localparam int HGROUPS = (sgb_pkg::TAPS + 3) / 4;
  localparam int VGROUPS = (sgb_pkg::SLOTS + 3) / 4;
  localparam int HPART_W = sgb_pkg::HPROD_W + 2;
  localparam int HACC_W  = HPART_W + $clog2(HGROUPS);
  localparam int VPART_W = sgb_pkg::VPROD_W + 2;
  localparam int VACC_W  = VPART_W + $clog2(VGROUPS);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_HMUL = 8'b0000_0010,
    ST_HSUM = 8'b0000_0100,
    ST_HWR  = 8'b0000_1000,
    ST_VCHK = 8'b0001_0000,
    ST_VMUL = 8'b0010_0000,
    ST_VSUM = 8'b0100_0000,
    ST_VOUT = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [sgb_pkg::DIM_W-1:0] width_r, height_r;
  logic [sgb_pkg::RAD_W-1:0] radius_r;
  logic [sgb_pkg::WGT_W-1:0] wlow_r, whigh_r;
  logic [sgb_pkg::DIM_W-1:0] cfg_dim;
  logic [sgb_pkg::DIM_W-1:0] cfg_dim_cl;
  logic                      restart;

  // Stream position.
  logic [sgb_pkg::XW-1:0]     col_r, col_nxt;
  logic [sgb_pkg::SLOT_W-1:0] in_slot_r, in_slot_nxt;
  logic [sgb_pkg::SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [sgb_pkg::CNT_W-1:0]  pending_r, pending_nxt;
  logic [sgb_pkg::OCNT_W-1:0] ocount_r, ocount_nxt;
  logic [sgb_pkg::XW-1:0]     out_x_r, out_x_nxt;
  logic [sgb_pkg::XW-1:0]     out_y_r, out_y_nxt;

  // Horizontal job of the current beat.
  logic [sgb_pkg::XW-1:0]     xi_r, xi_nxt;
  logic [sgb_pkg::SLOT_W-1:0] wslot_r, wslot_nxt;
  logic                       eor_r, eor_nxt;
  logic [2:0]                 hj_r, hj_nxt;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic [sgb_pkg::PIX_W-1:0]  out_pixel_r, out_pixel_nxt;
  logic                       out_eof_r, out_eof_nxt;

  // Derived geometry.
  logic [21:0]                total_full;
  logic [sgb_pkg::CNT_W-1:0]  total;
  logic [13:0]                lag_full;
  logic [sgb_pkg::LAG_W-1:0]  lag;
  logic [sgb_pkg::CNT_W-1:0]  remain;
  logic                       emit;
  logic                       eor_now;
  logic                       in_acc;
  logic                       out_take;
  logic                       out_free;

  // Cell rows.
  sgb_pkg::hctl_t             hctl;
  sgb_pkg::vctl_t             vctl;
  logic [sgb_pkg::PIX_W-1:0]   hpix [sgb_pkg::TAPS];
  logic [sgb_pkg::HPROD_W-1:0] hprod [sgb_pkg::TAPS];
  logic [sgb_pkg::VPROD_W-1:0] vprod [sgb_pkg::SLOTS];
  logic [HPART_W-1:0]          hgrp [HGROUPS];
  logic [HPART_W-1:0]          hpart_r [HGROUPS];
  logic [VPART_W-1:0]          vgrp [VGROUPS];
  logic [VPART_W-1:0]          vpart_r [VGROUPS];
  logic [HACC_W-1:0]           hacc;
  logic [HACC_W-8:0]           hsh;
  logic [sgb_pkg::HSUM_W-1:0]  hsum;
  logic [VACC_W-1:0]           vacc;
  logic [VACC_W-24:0]          vsh;
  logic [sgb_pkg::PIX_W-1:0]   vpix;
  logic [sgb_pkg::XW-1:0]      waddr;

  // Handshakes.
  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_take = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Configuration writes, clamped to the legal ranges.
  always_comb begin
    cfg_dim = cfg_wdata[sgb_pkg::DIM_W-1:0];
    if (cfg_dim == '0) begin
      cfg_dim_cl = 11'd1;
    end else if (cfg_dim > 11'(sgb_pkg::MAX_WIDTH)) begin
      cfg_dim_cl = 11'(sgb_pkg::MAX_WIDTH);
    end else begin
      cfg_dim_cl = cfg_dim;
    end
    restart = cfg_we && ((cfg_index == sgb_pkg::REG_WIDTH) ||
                         (cfg_index == sgb_pkg::REG_HEIGHT) ||
                         (cfg_index == sgb_pkg::REG_RADIUS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'(sgb_pkg::MAX_WIDTH);
      height_r <= 11'(sgb_pkg::MAX_HEIGHT);
      radius_r <= '0;
      wlow_r   <= 64'd32768;
      whigh_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        sgb_pkg::REG_WIDTH:  width_r  <= cfg_dim_cl;
        sgb_pkg::REG_HEIGHT: height_r <= cfg_dim_cl;
        sgb_pkg::REG_RADIUS: radius_r <= cfg_wdata[sgb_pkg::RAD_W-1:0];
        sgb_pkg::REG_WLOW:   wlow_r   <= cfg_wdata;
        sgb_pkg::REG_WHIGH:  whigh_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Frame size and output lag.
  always_comb begin
    total_full = width_r * height_r;
    total      = total_full[sgb_pkg::CNT_W-1:0];
    lag_full   = ({11'b0, radius_r} * {3'b0, width_r}) + {11'b0, radius_r};
    lag        = lag_full[sgb_pkg::LAG_W-1:0];
    remain     = total - {1'b0, ocount_r};
    emit       = (pending_r != '0) &&
                 ((pending_r > {8'b0, lag}) || (pending_r >= remain));
    eor_now    = ({1'b0, col_r} == (width_r - 11'd1));
  end

  // Horizontal cell row.
  genvar gk;
  generate
    for (gk = 0; gk < sgb_pkg::TAPS; gk++) begin : g_hcell
      sgb_hcell u_hcell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (hctl),
        .cell_k (sgb_pkg::TAP_W'(gk)),
        .tgt_j  (hj_r),
        .radius (radius_r),
        .wlow   (wlow_r),
        .whigh  (whigh_r),
        .pix_i  ((gk == 0) ? in_pixel : hpix[(gk == 0) ? 0 : gk - 1]),
        .pix_o  (hpix[gk]),
        .prod_o (hprod[gk])
      );
    end
  endgenerate

  // Vertical cell row, one line bank per cell.
  generate
    for (gk = 0; gk < sgb_pkg::SLOTS; gk++) begin : g_vcell
      sgb_vcell u_vcell (
        .clk      (clk),
        .ctl      (vctl),
        .cell_id  (sgb_pkg::SLOT_W'(gk)),
        .wslot    (wslot_r),
        .waddr    (waddr),
        .wdata    (hsum),
        .raddr    (out_x_r),
        .out_slot (out_slot_r),
        .radius   (radius_r),
        .out_y    (out_y_r),
        .height   (height_r),
        .wlow     (wlow_r),
        .whigh    (whigh_r),
        .prod_o   (vprod[gk])
      );
    end
  endgenerate

  // Partial sums of the tap products, four per group.
  always_comb begin
    for (int g = 0; g < HGROUPS; g++) begin
      hgrp[g] = '0;
      for (int i = 0; i < 4; i++) begin
        if (4 * g + i < sgb_pkg::TAPS) begin
          hgrp[g] = hgrp[g] + HPART_W'(hprod[4 * g + i]);
        end
      end
    end
    for (int g = 0; g < VGROUPS; g++) begin
      vgrp[g] = '0;
      for (int i = 0; i < 4; i++) begin
        if (4 * g + i < sgb_pkg::SLOTS) begin
          vgrp[g] = vgrp[g] + VPART_W'(vprod[4 * g + i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_HSUM) begin
      for (int g = 0; g < HGROUPS; g++) begin
        hpart_r[g] <= hgrp[g];
      end
    end
    if (state_r == ST_VSUM) begin
      for (int g = 0; g < VGROUPS; g++) begin
        vpart_r[g] <= vgrp[g];
      end
    end
  end

  // Final sums, scaling and saturation.
  always_comb begin
    hacc = '0;
    for (int g = 0; g < HGROUPS; g++) begin
      hacc = hacc + HACC_W'(hpart_r[g]);
    end
    hsh  = hacc[HACC_W-1:7];
    hsum = (|hsh[HACC_W-8:sgb_pkg::HSUM_W]) ? '1 : hsh[sgb_pkg::HSUM_W-1:0];
    vacc = '0;
    for (int g = 0; g < VGROUPS; g++) begin
      vacc = vacc + VACC_W'(vpart_r[g]);
    end
    vsh   = vacc[VACC_W-1:23];
    vpix  = (|vsh[VACC_W-24:sgb_pkg::PIX_W]) ? '1 : vsh[sgb_pkg::PIX_W-1:0];
    waddr = xi_r - {7'b0, hj_r};
  end

  // Sequencer and stream bookkeeping.
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    in_slot_nxt   = in_slot_r;
    out_slot_nxt  = out_slot_r;
    pending_nxt   = pending_r;
    ocount_nxt    = ocount_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    xi_nxt        = xi_r;
    wslot_nxt     = wslot_r;
    eor_nxt       = eor_r;
    hj_nxt        = hj_r;
    out_valid_nxt = out_take ? 1'b0 : out_valid_r;
    out_pixel_nxt = out_pixel_r;
    out_eof_nxt   = out_eof_r;
    hctl          = '0;
    vctl          = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (!in_action) begin
            hctl.shift  = 1'b1;
            hctl.clr    = (col_r == '0);
            xi_nxt      = col_r;
            wslot_nxt   = in_slot_r;
            eor_nxt     = eor_now;
            hj_nxt      = (col_r >= {7'b0, radius_r}) ? radius_r : col_r[2:0];
            pending_nxt = pending_r + 1'b1;
            if (eor_now) begin
              col_nxt     = '0;
              in_slot_nxt = (in_slot_r == sgb_pkg::SLOT_W'(sgb_pkg::SLOTS - 1)) ?
                            '0 : in_slot_r + 1'b1;
            end else begin
              col_nxt = col_r + 1'b1;
            end
            state_nxt = ((col_r >= {7'b0, radius_r}) || eor_now) ? ST_HMUL : ST_VCHK;
          end else begin
            state_nxt = ST_VCHK;
          end
        end
      end
      ST_HMUL: begin
        hctl.mul  = 1'b1;
        state_nxt = ST_HSUM;
      end
      ST_HSUM: begin
        state_nxt = ST_HWR;
      end
      ST_HWR: begin
        vctl.we = 1'b1;
        if (eor_r && (hj_r != '0)) begin
          hj_nxt    = hj_r - 1'b1;
          state_nxt = ST_HMUL;
        end else begin
          state_nxt = ST_VCHK;
        end
      end
      ST_VCHK: begin
        if (emit) begin
          vctl.rd   = 1'b1;
          state_nxt = ST_VMUL;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_VMUL: begin
        vctl.mul  = 1'b1;
        state_nxt = ST_VSUM;
      end
      ST_VSUM: begin
        state_nxt = ST_VOUT;
      end
      ST_VOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pixel_nxt = vpix;
          out_eof_nxt   = ({1'b0, ocount_r} == (total - 1'b1));
          pending_nxt   = pending_r - 1'b1;
          if ({1'b0, out_x_r} == (width_r - 11'd1)) begin
            out_x_nxt    = '0;
            out_y_nxt    = out_y_r + 1'b1;
            out_slot_nxt = (out_slot_r == sgb_pkg::SLOT_W'(sgb_pkg::SLOTS - 1)) ?
                           '0 : out_slot_r + 1'b1;
          end else begin
            out_x_nxt = out_x_r + 1'b1;
          end
          if (({1'b0, ocount_r} + 1'b1) >= total) begin
            ocount_nxt = '0;
            out_x_nxt  = '0;
            out_y_nxt  = '0;
          end else begin
            ocount_nxt = ocount_r + 1'b1;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A geometry write restarts the stream.
    if (restart) begin
      hctl.wipe    = 1'b1;
      col_nxt      = '0;
      in_slot_nxt  = '0;
      out_slot_nxt = '0;
      pending_nxt  = '0;
      ocount_nxt   = '0;
      out_x_nxt    = '0;
      out_y_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      in_slot_r   <= '0;
      out_slot_r  <= '0;
      pending_r   <= '0;
      ocount_r    <= '0;
      out_x_r     <= '0;
      out_y_r     <= '0;
      eor_r       <= 1'b0;
      hj_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      in_slot_r   <= in_slot_nxt;
      out_slot_r  <= out_slot_nxt;
      pending_r   <= pending_nxt;
      ocount_r    <= ocount_nxt;
      out_x_r     <= out_x_nxt;
      out_y_r     <= out_y_nxt;
      eor_r       <= eor_nxt;
      hj_r        <= hj_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    xi_r        <= xi_nxt;
    wslot_r     <= wslot_nxt;
    out_pixel_r <= out_pixel_nxt;
    out_eof_r   <= out_eof_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pixel        = out_pixel_r;
  assign out_end_of_frame = out_eof_r;

endmodule

// File: design/sgb_checker.sv
// Port-level checker for the blur unit, bound to the top level.
`include "separable_gaussian_blur_unit_defines.svh"

module sgb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        in_action,
  input logic [sgb_pkg::PIX_W-1:0]   in_pixel,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [sgb_pkg::PIX_W-1:0]   out_pixel,
  input logic                        out_end_of_frame,
  input logic                        cfg_we,
  input logic [sgb_pkg::CIDX_W-1:0]  cfg_index,
  input logic [sgb_pkg::WGT_W-1:0]   cfg_wdata
);

  // A stalled result beat holds its payload.
  `SGB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_pixel) && $stable(out_end_of_frame))

  // The unit works on one input beat at a time.
  `SGB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // A new result only comes out of a busy sequencer.
  `SGB_ASSERT_NOW(a_result_from_work, clk, rst_n, $rose(out_valid), $past(in_stall))

endmodule

bind separable_gaussian_blur_unit sgb_checker u_sgb_checker (.*);
